### design/rv64im_instruction_execute_defines.svh
`ifndef RV64IM_INSTRUCTION_EXECUTE_DEFINES_SVH
`define RV64IM_INSTRUCTION_EXECUTE_DEFINES_SVH

// same-cycle implication
`define RV64IE_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define RV64IE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

### design/rv64ie_pkg.sv
package rv64ie_pkg;

    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_JAL      = 7'h6f;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_OPIMM    = 7'h13;
    localparam logic [6:0] OPC_OPIMM32  = 7'h1b;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_OP32     = 7'h3b;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0f;

    localparam logic [31:0] INS_ECALL   = 32'h0000_0073;
    localparam logic [31:0] INS_EBREAK  = 32'h0010_0073;
    localparam logic [31:0] INS_MRET    = 32'h3020_0073;
    localparam logic [31:0] INS_FENCE_I = 32'h0000_100f;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [2:0] TRAP_NONE    = 3'd0;
    localparam logic [2:0] TRAP_ILLEGAL = 3'd1;
    localparam logic [2:0] TRAP_ECALL   = 3'd2;
    localparam logic [2:0] TRAP_EBREAK  = 3'd3;
    localparam logic [2:0] TRAP_SYSTEM  = 3'd4;

    localparam logic [2:0] MUL_LOW    = 3'd0;
    localparam logic [2:0] MUL_HIGH   = 3'd1;
    localparam logic [2:0] MUL_HIGHSU = 3'd2;
    localparam logic [2:0] MUL_HIGHU  = 3'd3;

    typedef enum logic [1:0] {
        EXE_NONE,
        EXE_ALU,
        EXE_MUL,
        EXE_DIV
    } t_kind;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLL,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_SRL,
        ALU_SRA,
        ALU_OR,
        ALU_AND
    } t_alu;

    typedef struct packed {
        logic [4:0]  rd_index;
        logic        rd_write;
        logic [63:0] rd_value;
        logic [63:0] next_pc;
        logic        branch_taken;
        logic [1:0]  mem_kind;
        logic [63:0] mem_address;
        logic [1:0]  mem_size_log2;
        logic        load_signed;
        logic [63:0] store_data;
        logic [2:0]  trap_kind;
    } t_res;

    typedef struct packed {
        t_res        res;
        t_kind       kind;
        t_alu        alu;
        logic [2:0]  f3;
        logic        word;
        logic [63:0] a;
        logic [63:0] b;
    } t_uop;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

### design/rv64im_instruction_execute.sv
// channel   direction  handshake          payload
// input     in         push / full        instruction, pc, rs1_value, rs2_value
// result    out        empty / pop        rd_*, next_pc, branch_taken, mem_*, store_data,
//                                         trap_kind
//
// one instruction per cycle sustained while results are popped, every operation class alike
// accept to result runs through the uop queue, the 64-step divider pipeline and the result queue
// reset clears the queue counts and pointers and the pipeline valid bits, nothing else
// a held pop freezes the execute pipeline once its last stage is blocked; the queues then
// fill and full rises
module rv64im_instruction_execute #(
    parameter int QUEUE_DEPTH = 2,
    parameter int OUT_DEPTH   = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_instruction,
    input  logic [63:0] i_pc,
    input  logic [63:0] i_rs1_value,
    input  logic [63:0] i_rs2_value,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_rd_index,
    output logic        o_rd_write,
    output logic [63:0] o_rd_value,
    output logic [63:0] o_next_pc,
    output logic        o_branch_taken,
    output logic [1:0]  o_mem_kind,
    output logic [63:0] o_mem_address,
    output logic [1:0]  o_mem_size_log2,
    output logic        o_load_signed,
    output logic [63:0] o_store_data,
    output logic [2:0]  o_trap_kind
);
    import rv64ie_pkg::*;

    t_uop w_dec_uop;
    t_uop w_q_uop;
    logic w_q_empty;
    logic w_q_pop;
    logic w_res_push;
    t_res w_res;
    logic w_out_full;
    t_res w_out;

    rv64ie_front u_front (
        .i_instruction (i_instruction),
        .i_pc          (i_pc),
        .i_rs1_value   (i_rs1_value),
        .i_rs2_value   (i_rs2_value),
        .o_uop         (w_dec_uop)
    );

    rv64ie_fifo #(
        .WIDTH ($bits(t_uop)),
        .DEPTH (QUEUE_DEPTH)
    ) u_uop_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_dec_uop),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_uop),
        .o_empty (w_q_empty)
    );

    rv64ie_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uop      (w_q_uop),
        .i_empty    (w_q_empty),
        .o_pop      (w_q_pop),
        .o_push     (w_res_push),
        .o_res      (w_res),
        .i_out_full (w_out_full)
    );

    rv64ie_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty)
    );

    assign o_rd_index      = w_out.rd_index;
    assign o_rd_write      = w_out.rd_write;
    assign o_rd_value      = w_out.rd_value;
    assign o_next_pc       = w_out.next_pc;
    assign o_branch_taken  = w_out.branch_taken;
    assign o_mem_kind      = w_out.mem_kind;
    assign o_mem_address   = w_out.mem_address;
    assign o_mem_size_log2 = w_out.mem_size_log2;
    assign o_load_signed   = w_out.load_signed;
    assign o_store_data    = w_out.store_data;
    assign o_trap_kind     = w_out.trap_kind;

endmodule

### design/rv64ie_fifo.sv
`include "rv64im_instruction_execute_defines.svh"

module rv64ie_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push_ok && !w_pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `RV64IE_ASSERT_NEXT(a_fifo_grow, i_clk, i_rst_n, w_push_ok && !w_pop_ok, r_count == CNT_W'($past(r_count) + 1'b1))
    `RV64IE_ASSERT_NEXT(a_fifo_shrink, i_clk, i_rst_n, !w_push_ok && w_pop_ok, r_count == CNT_W'($past(r_count) - 1'b1))
    `RV64IE_ASSERT_NEXT(a_fifo_hold, i_clk, i_rst_n, w_push_ok && w_pop_ok, $stable(r_count) && !o_empty)

endmodule

### design/rv64ie_front.sv
module rv64ie_front (
    input  logic [31:0]       i_instruction,
    input  logic [63:0]       i_pc,
    input  logic [63:0]       i_rs1_value,
    input  logic [63:0]       i_rs2_value,
    output rv64ie_pkg::t_uop  o_uop
);
    import rv64ie_pkg::*;

    logic [6:0]  w_opc;
    logic [2:0]  w_f3;
    logic [6:0]  w_f7;
    logic [4:0]  w_rd;
    logic [63:0] w_imm_i, w_imm_s, w_imm_b, w_imm_u, w_imm_j;
    logic [63:0] w_pc_imm, w_rs_imm, w_snpc;
    logic        w_eq, w_lt, w_ltu;

    assign w_opc = i_instruction[6:0];
    assign w_f3  = i_instruction[14:12];
    assign w_f7  = i_instruction[31:25];
    assign w_rd  = i_instruction[11:7];

    assign w_imm_i = {{52{i_instruction[31]}}, i_instruction[31:20]};
    assign w_imm_s = {{52{i_instruction[31]}}, i_instruction[31:25], i_instruction[11:7]};
    assign w_imm_b = {{51{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                      i_instruction[30:25], i_instruction[11:8], 1'b0};
    assign w_imm_u = {{32{i_instruction[31]}}, i_instruction[31:12], 12'h000};
    assign w_imm_j = {{43{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                      i_instruction[20], i_instruction[30:21], 1'b0};

    assign w_snpc   = i_pc + 64'd4;
    assign w_pc_imm = i_pc + ((w_opc == OPC_JAL) ? w_imm_j :
                              (w_opc == OPC_BRANCH) ? w_imm_b : w_imm_u);
    assign w_rs_imm = i_rs1_value + ((w_opc == OPC_STORE) ? w_imm_s : w_imm_i);

    assign w_eq  = (i_rs1_value == i_rs2_value);
    assign w_lt  = ($signed(i_rs1_value) < $signed(i_rs2_value));
    assign w_ltu = (i_rs1_value < i_rs2_value);

    always_comb begin
        logic        has_rd;
        logic        ill;
        logic        cond;
        logic [2:0]  trap;
        t_uop        u;

        has_rd = 1'b0;
        ill    = 1'b0;
        cond   = 1'b0;
        trap   = TRAP_NONE;
        u      = '0;
        u.kind = EXE_NONE;
        u.alu  = ALU_ADD;
        u.f3   = w_f3;
        u.a    = i_rs1_value;
        u.b    = i_rs2_value;
        u.res.next_pc = w_snpc;

        case (w_opc)
            OPC_LUI: begin
                has_rd = 1'b1;
                u.res.rd_value = w_imm_u;
            end
            OPC_AUIPC: begin
                has_rd = 1'b1;
                u.res.rd_value = w_pc_imm;
            end
            OPC_JAL: begin
                has_rd = 1'b1;
                u.res.rd_value = w_snpc;
                u.res.next_pc = w_pc_imm;
                u.res.branch_taken = 1'b1;
            end
            OPC_JALR: begin
                if (w_f3 != 3'd0) begin
                    ill = 1'b1;
                end else begin
                    has_rd = 1'b1;
                    u.res.rd_value = w_snpc;
                    u.res.next_pc = {w_rs_imm[63:1], 1'b0};
                    u.res.branch_taken = 1'b1;
                end
            end
            OPC_BRANCH: begin
                case (w_f3)
                    3'd0: cond = w_eq;
                    3'd1: cond = !w_eq;
                    3'd4: cond = w_lt;
                    3'd5: cond = !w_lt;
                    3'd6: cond = w_ltu;
                    3'd7: cond = !w_ltu;
                    default: ill = 1'b1;
                endcase
                if (!ill && cond) begin
                    u.res.next_pc = w_pc_imm;
                    u.res.branch_taken = 1'b1;
                end
            end
            OPC_LOAD: begin
                if (w_f3 == 3'd7) begin
                    ill = 1'b1;
                end else begin
                    has_rd = 1'b1;
                    u.res.mem_kind = MEM_LOAD;
                    u.res.mem_address = w_rs_imm;
                    u.res.mem_size_log2 = w_f3[1:0];
                    u.res.load_signed = (w_f3 < 3'd3);
                end
            end
            OPC_STORE: begin
                if (w_f3[2]) begin
                    ill = 1'b1;
                end else begin
                    u.res.mem_kind = MEM_STORE;
                    u.res.mem_address = w_rs_imm;
                    u.res.mem_size_log2 = w_f3[1:0];
                    case (w_f3[1:0])
                        2'd0: u.res.store_data = {56'h0, i_rs2_value[7:0]};
                        2'd1: u.res.store_data = {48'h0, i_rs2_value[15:0]};
                        2'd2: u.res.store_data = {32'h0, i_rs2_value[31:0]};
                        default: u.res.store_data = i_rs2_value;
                    endcase
                end
            end
            OPC_OPIMM: begin
                has_rd = 1'b1;
                u.kind = EXE_ALU;
                u.b = w_imm_i;
                case (w_f3)
                    3'd0: u.alu = ALU_ADD;
                    3'd2: u.alu = ALU_SLT;
                    3'd3: u.alu = ALU_SLTU;
                    3'd4: u.alu = ALU_XOR;
                    3'd6: u.alu = ALU_OR;
                    3'd7: u.alu = ALU_AND;
                    3'd1: begin
                        if (w_f7[6:1] == 6'h00) u.alu = ALU_SLL;
                        else ill = 1'b1;
                    end
                    default: begin
                        if (w_f7[6:1] == 6'h00) u.alu = ALU_SRL;
                        else if (w_f7[6:1] == 6'h10) u.alu = ALU_SRA;
                        else ill = 1'b1;
                    end
                endcase
            end
            OPC_OPIMM32: begin
                has_rd = 1'b1;
                u.kind = EXE_ALU;
                u.word = 1'b1;
                u.b = w_imm_i;
                if (w_f3 == 3'd0) begin
                    u.alu = ALU_ADD;
                end else if (w_f3 == 3'd1 && w_f7 == F7_BASE) begin
                    u.alu = ALU_SLL;
                end else if (w_f3 == 3'd5 && w_f7 == F7_BASE) begin
                    u.alu = ALU_SRL;
                    u.a = {32'h0, i_rs1_value[31:0]};
                end else if (w_f3 == 3'd5 && w_f7 == F7_ALT) begin
                    u.alu = ALU_SRA;
                    u.a = sext32(i_rs1_value[31:0]);
                end else begin
                    ill = 1'b1;
                end
            end
            OPC_OP: begin
                has_rd = 1'b1;
                if (w_f7 == F7_BASE) begin
                    u.kind = EXE_ALU;
                    case (w_f3)
                        3'd0: u.alu = ALU_ADD;
                        3'd1: u.alu = ALU_SLL;
                        3'd2: u.alu = ALU_SLT;
                        3'd3: u.alu = ALU_SLTU;
                        3'd4: u.alu = ALU_XOR;
                        3'd5: u.alu = ALU_SRL;
                        3'd6: u.alu = ALU_OR;
                        default: u.alu = ALU_AND;
                    endcase
                end else if (w_f7 == F7_ALT && w_f3 == 3'd0) begin
                    u.kind = EXE_ALU;
                    u.alu = ALU_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                    u.kind = EXE_ALU;
                    u.alu = ALU_SRA;
                end else if (w_f7 == F7_MULDIV) begin
                    u.kind = w_f3[2] ? EXE_DIV : EXE_MUL;
                end else begin
                    ill = 1'b1;
                end
            end
            OPC_OP32: begin
                has_rd = 1'b1;
                u.word = 1'b1;
                if (w_f7 == F7_BASE && w_f3 == 3'd0) begin
                    u.kind = EXE_ALU;
                    u.alu = ALU_ADD;
                end else if (w_f7 == F7_BASE && w_f3 == 3'd1) begin
                    u.kind = EXE_ALU;
                    u.alu = ALU_SLL;
                end else if (w_f7 == F7_BASE && w_f3 == 3'd5) begin
                    u.kind = EXE_ALU;
                    u.alu = ALU_SRL;
                    u.a = {32'h0, i_rs1_value[31:0]};
                end else if (w_f7 == F7_ALT && w_f3 == 3'd0) begin
                    u.kind = EXE_ALU;
                    u.alu = ALU_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                    u.kind = EXE_ALU;
                    u.alu = ALU_SRA;
                    u.a = sext32(i_rs1_value[31:0]);
                end else if (w_f7 == F7_MULDIV && w_f3 == 3'd0) begin
                    u.kind = EXE_MUL;
                end else if (w_f7 == F7_MULDIV && w_f3 inside {3'd4, 3'd6}) begin
                    u.kind = EXE_DIV;
                    u.a = sext32(i_rs1_value[31:0]);
                    u.b = sext32(i_rs2_value[31:0]);
                end else if (w_f7 == F7_MULDIV && w_f3 inside {3'd5, 3'd7}) begin
                    u.kind = EXE_DIV;
                    u.a = {32'h0, i_rs1_value[31:0]};
                    u.b = {32'h0, i_rs2_value[31:0]};
                end else begin
                    ill = 1'b1;
                end
            end
            OPC_SYSTEM: begin
                if (i_instruction == INS_EBREAK) trap = TRAP_EBREAK;
                else if (i_instruction == INS_ECALL) trap = TRAP_ECALL;
                else if (i_instruction == INS_MRET || !(w_f3 inside {3'd0, 3'd4}))
                    trap = TRAP_SYSTEM;
                else ill = 1'b1;
            end
            OPC_MISC_MEM: begin
                if (i_instruction == INS_FENCE_I) trap = TRAP_SYSTEM;
                else ill = 1'b1;
            end
            default: ill = 1'b1;
        endcase

        if (ill) trap = TRAP_ILLEGAL;
        if (trap != TRAP_NONE) begin
            has_rd = 1'b0;
            u.kind = EXE_NONE;
            u.res.branch_taken = 1'b0;
            u.res.next_pc = w_snpc;
            u.res.mem_kind = MEM_NONE;
            u.res.mem_address = '0;
            u.res.mem_size_log2 = '0;
            u.res.load_signed = 1'b0;
            u.res.store_data = '0;
        end
        if (!has_rd || u.res.mem_kind == MEM_LOAD) begin
            u.res.rd_value = '0;
            u.kind = EXE_NONE;
        end
        u.res.trap_kind = trap;
        u.res.rd_index = has_rd ? w_rd : 5'd0;
        u.res.rd_write = has_rd && (w_rd != 5'd0);
        o_uop = u;
    end

endmodule

### design/rv64ie_back.sv
`include "rv64im_instruction_execute_defines.svh"

module rv64ie_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rv64ie_pkg::t_uop  i_uop,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_push,
    output rv64ie_pkg::t_res  o_res,
    input  logic              i_out_full
);
    import rv64ie_pkg::*;

    localparam int DIV_STEPS = 64;
    localparam int LAST      = DIV_STEPS + 1;
    localparam int MUL_DONE  = 4;

    typedef struct packed {
        t_res        res;
        t_kind       kind;
        logic [2:0]  f3;
        logic        word;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] den;
        logic        negq;
        logic        negr;
        logic        dz;
    } t_stage;

    t_stage        r_st [1:LAST];
    t_stage        n_st [1:LAST];
    logic [LAST:1] r_vld;
    logic          w_en;
    t_res          w_fin;

    logic [63:0]  r_m_ll, r_m_lh, r_m_hl, r_m_hh;
    logic [63:0]  r_m_ll2, r_m_hh2;
    logic [64:0]  r_m_mid;
    logic [127:0] r_m_full;

    assign w_en   = !r_vld[LAST] || !i_out_full;
    assign o_pop  = w_en && !i_empty;
    assign o_push = r_vld[LAST] && !i_out_full;
    assign o_res  = w_fin;

    always_comb begin
        logic [63:0] alu;
        logic [5:0]  sh;
        logic        sa, sb;
        t_stage      s;

        sh = i_uop.b[5:0] & {~i_uop.word, 5'h1f};
        case (i_uop.alu)
            ALU_ADD:  alu = i_uop.a + i_uop.b;
            ALU_SUB:  alu = i_uop.a - i_uop.b;
            ALU_SLL:  alu = i_uop.a << sh;
            ALU_SLT:  alu = {63'h0, $signed(i_uop.a) < $signed(i_uop.b)};
            ALU_SLTU: alu = {63'h0, i_uop.a < i_uop.b};
            ALU_XOR:  alu = i_uop.a ^ i_uop.b;
            ALU_SRL:  alu = i_uop.a >> sh;
            ALU_SRA:  alu = $unsigned($signed(i_uop.a) >>> sh);
            ALU_OR:   alu = i_uop.a | i_uop.b;
            ALU_AND:  alu = i_uop.a & i_uop.b;
            default:  alu = '0;
        endcase
        if (i_uop.word) alu = sext32(alu[31:0]);

        sa = !i_uop.f3[0] && i_uop.a[63];
        sb = !i_uop.f3[0] && i_uop.b[63];

        s      = '0;
        s.res  = i_uop.res;
        s.kind = i_uop.kind;
        s.f3   = i_uop.f3;
        s.word = i_uop.word;
        case (i_uop.kind)
            EXE_ALU: s.res.rd_value = alu;
            EXE_MUL: begin
                s.den = (((i_uop.f3 == MUL_HIGH) || (i_uop.f3 == MUL_HIGHSU)) && i_uop.a[63]
                         ? i_uop.b : 64'h0)
                      + ((i_uop.f3 == MUL_HIGH) && i_uop.b[63] ? i_uop.a : 64'h0);
            end
            EXE_DIV: begin
                s.quo  = sa ? (64'h0 - i_uop.a) : i_uop.a;
                s.den  = sb ? (64'h0 - i_uop.b) : i_uop.b;
                s.negq = sa ^ sb;
                s.negr = sa;
                s.dz   = (i_uop.b == 64'h0);
                s.res.rd_value = i_uop.a;
            end
            default: ;
        endcase
        n_st[1] = s;
    end

    for (genvar gi = 2; gi <= LAST; gi++) begin : g_stage
        always_comb begin
            logic [64:0] shifted;
            logic [64:0] diff;
            logic        ge;
            logic [63:0] hu;
            t_stage      s;

            s       = r_st[gi-1];
            shifted = {s.rem, s.quo[63]};
            diff    = shifted - {1'b0, s.den};
            ge      = (shifted >= {1'b0, s.den});
            hu      = r_m_full[127:64];
            if (s.kind == EXE_DIV) begin
                s.rem = ge ? diff[63:0] : shifted[63:0];
                s.quo = {s.quo[62:0], ge};
            end
            if (gi == MUL_DONE && s.kind == EXE_MUL) begin
                case (s.f3)
                    MUL_LOW:   s.res.rd_value = s.word ? sext32(r_m_full[31:0])
                                                       : r_m_full[63:0];
                    MUL_HIGHU: s.res.rd_value = hu;
                    default:   s.res.rd_value = hu - s.den;
                endcase
            end
            n_st[gi] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 1; i <= LAST; i++) begin
                r_st[i] <= n_st[i];
            end
            r_m_ll   <= i_uop.a[31:0] * i_uop.b[31:0];
            r_m_lh   <= i_uop.a[31:0] * i_uop.b[63:32];
            r_m_hl   <= i_uop.a[63:32] * i_uop.b[31:0];
            r_m_hh   <= i_uop.a[63:32] * i_uop.b[63:32];
            r_m_mid  <= {1'b0, r_m_lh} + {1'b0, r_m_hl};
            r_m_ll2  <= r_m_ll;
            r_m_hh2  <= r_m_hh;
            r_m_full <= {r_m_hh2, r_m_ll2} + {31'h0, r_m_mid, 32'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:1], o_pop};
        end
    end

    always_comb begin
        logic [63:0] q, r, v;
        t_stage      s;

        s = r_st[LAST];
        q = s.negq ? (64'h0 - s.quo) : s.quo;
        r = s.negr ? (64'h0 - s.rem) : s.rem;
        if (s.dz) begin
            q = '1;
            r = s.res.rd_value;
        end
        v = s.res.rd_value;
        if (s.kind == EXE_DIV) begin
            v = s.f3[1] ? r : q;
            if (s.word) v = sext32(v[31:0]);
        end
        w_fin = s.res;
        w_fin.rd_value = s.res.rd_write ? v : 64'h0;
    end

    `RV64IE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_vld[LAST] && i_out_full, r_vld[LAST] && $stable(r_st[LAST]))
    `RV64IE_ASSERT_IMPL(a_trap_quiet, i_clk, i_rst_n, r_vld[LAST] && w_fin.trap_kind != TRAP_NONE, !w_fin.rd_write && w_fin.mem_kind == MEM_NONE && !w_fin.branch_taken)
    `RV64IE_ASSERT_IMPL(a_zero_dest, i_clk, i_rst_n, r_vld[LAST] && !w_fin.rd_write, w_fin.rd_value == 64'h0)

endmodule

### test/rv64ie_checker.sv
module rv64ie_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] i_instruction,
    input  logic [63:0] i_pc,
    input  logic [63:0] i_rs1_value,
    input  logic [63:0] i_rs2_value,
    input  logic        empty,
    input  logic        pop,
    input  logic [4:0]  o_rd_index,
    input  logic        o_rd_write,
    input  logic [63:0] o_rd_value,
    input  logic [63:0] o_next_pc,
    input  logic        o_branch_taken,
    input  logic [1:0]  o_mem_kind,
    input  logic [63:0] o_mem_address,
    input  logic [1:0]  o_mem_size_log2,
    input  logic        o_load_signed,
    input  logic [63:0] o_store_data,
    input  logic [2:0]  o_trap_kind,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rv64ie_pkg::*;

    t_res expected_results[$];

    assign o_pending = expected_results.size();

    initial o_fail_count = 0;

    function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
        logic [63:0] m;
        m = (bits >= 64) ? '1 : ((64'd1 << bits) - 1);
        v = v & m;
        return (v ^ (64'd1 << (bits - 1))) - (64'd1 << (bits - 1));
    endfunction

    function automatic logic [63:0] sdiv_rem(input logic [63:0] a, input logic [63:0] b,
                                             input int bits, input bit want_rem);
        logic [63:0] minv;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        logic [63:0] r;
        minv = sx(64'd1 << (bits - 1), bits);
        if (b == 0) return want_rem ? a : '1;
        if (a == minv && b == '1) return want_rem ? 64'd0 : a;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q = ua / ub;
        r = ua % ub;
        if (a[63] != b[63]) q = -q;
        if (a[63]) r = -r;
        return want_rem ? r : q;
    endfunction

    function automatic t_res execute_instruction(input logic [31:0] ins, input logic [63:0] pc,
                                                 input logic [63:0] a, input logic [63:0] b);
        t_res r;
        logic [6:0] f7;
        logic [2:0] f3;
        logic [63:0] imm_i;
        logic [63:0] imm_s;
        logic [63:0] imm_b;
        logic [63:0] imm_u;
        logic [63:0] imm_j;
        logic [63:0] seq_pc;
        logic [63:0] val;
        logic [127:0] prod;
        logic [5:0] sh;
        logic [31:0] aw;
        logic [31:0] bw;
        bit has_rd;
        bit ill;
        bit cond;
        f7 = ins[31:25];
        f3 = ins[14:12];
        imm_i = sx({52'd0, ins[31:20]}, 12);
        imm_s = sx({52'd0, ins[31:25], ins[11:7]}, 12);
        imm_b = sx({51'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        imm_u = sx({32'd0, ins[31:12], 12'd0}, 32);
        imm_j = sx({43'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        seq_pc = pc + 4;
        sh = imm_i[5:0];
        aw = a[31:0];
        bw = b[31:0];
        r = '0;
        r.next_pc = seq_pc;
        has_rd = 0;
        ill = 0;
        val = 0;
        cond = 0;
        case (ins[6:0])
            OPC_LUI: begin has_rd = 1; val = imm_u; end
            OPC_AUIPC: begin has_rd = 1; val = pc + imm_u; end
            OPC_JAL: begin
                has_rd = 1; val = seq_pc; r.next_pc = pc + imm_j; r.branch_taken = 1;
            end
            OPC_JALR: begin
                if (f3 != 0) ill = 1;
                else begin
                    has_rd = 1; val = seq_pc;
                    r.next_pc = (a + imm_i) & ~64'd1; r.branch_taken = 1;
                end
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0: cond = a == b;
                    3'd1: cond = a != b;
                    3'd4: cond = $signed(a) < $signed(b);
                    3'd5: cond = $signed(a) >= $signed(b);
                    3'd6: cond = a < b;
                    3'd7: cond = a >= b;
                    default: ill = 1;
                endcase
                if (!ill && cond) begin r.next_pc = pc + imm_b; r.branch_taken = 1; end
            end
            OPC_LOAD: begin
                if (f3 == 7) ill = 1;
                else begin
                    has_rd = 1; r.mem_kind = MEM_LOAD; r.mem_address = a + imm_i;
                    r.mem_size_log2 = f3[1:0]; r.load_signed = f3 < 3;
                end
            end
            OPC_STORE: begin
                if (f3 > 3) ill = 1;
                else begin
                    r.mem_kind = MEM_STORE; r.mem_address = a + imm_s;
                    r.mem_size_log2 = f3[1:0];
                    r.store_data = (f3 == 3) ? b : b & ((64'd1 << (8 << f3)) - 1);
                end
            end
            OPC_OPIMM: begin
                has_rd = 1;
                case (f3)
                    3'd0: val = a + imm_i;
                    3'd2: val = 64'($signed(a) < $signed(imm_i));
                    3'd3: val = 64'(a < imm_i);
                    3'd4: val = a ^ imm_i;
                    3'd6: val = a | imm_i;
                    3'd7: val = a & imm_i;
                    3'd1: if (f7[6:1] == 0) val = a << sh; else ill = 1;
                    default: begin
                        if (f7[6:1] == 0) val = a >> sh;
                        else if (f7[6:1] == 6'h10) val = $signed(a) >>> sh;
                        else ill = 1;
                    end
                endcase
            end
            OPC_OPIMM32: begin
                has_rd = 1;
                if (f3 == 0) val = sx(a + imm_i, 32);
                else if (f3 == 1 && f7 == F7_BASE) val = sx(64'(aw << sh[4:0]), 32);
                else if (f3 == 5 && f7 == F7_BASE) val = sx(64'(aw >> sh[4:0]), 32);
                else if (f3 == 5 && f7 == F7_ALT) val = sx(64'($signed(aw) >>> sh[4:0]), 32);
                else ill = 1;
            end
            OPC_OP: begin
                has_rd = 1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0: val = a + b;
                        3'd1: val = a << b[5:0];
                        3'd2: val = 64'($signed(a) < $signed(b));
                        3'd3: val = 64'(a < b);
                        3'd4: val = a ^ b;
                        3'd5: val = a >> b[5:0];
                        3'd6: val = a | b;
                        default: val = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == 0) val = a - b;
                else if (f7 == F7_ALT && f3 == 5) val = $signed(a) >>> b[5:0];
                else if (f7 == F7_MULDIV) begin
                    case (f3)
                        MUL_LOW: val = a * b;
                        MUL_HIGH: begin
                            prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                            val = prod[127:64];
                        end
                        MUL_HIGHSU: begin
                            prod = {{64{a[63]}}, a} * {64'd0, b};
                            val = prod[127:64];
                        end
                        MUL_HIGHU: begin
                            prod = {64'd0, a} * {64'd0, b};
                            val = prod[127:64];
                        end
                        3'd4: val = sdiv_rem(a, b, 64, 0);
                        3'd5: val = (b == 0) ? '1 : a / b;
                        3'd6: val = sdiv_rem(a, b, 64, 1);
                        default: val = (b == 0) ? a : a % b;
                    endcase
                end else ill = 1;
            end
            OPC_OP32: begin
                has_rd = 1;
                if (f7 == F7_BASE && f3 == 0) val = sx(a + b, 32);
                else if (f7 == F7_BASE && f3 == 1) val = sx(64'(aw << bw[4:0]), 32);
                else if (f7 == F7_BASE && f3 == 5) val = sx(64'(aw >> bw[4:0]), 32);
                else if (f7 == F7_ALT && f3 == 0) val = sx(a - b, 32);
                else if (f7 == F7_ALT && f3 == 5) val = sx(64'($signed(aw) >>> bw[4:0]), 32);
                else if (f7 == F7_MULDIV && f3 == 0) val = sx(a * b, 32);
                else if (f7 == F7_MULDIV && f3 == 4)
                    val = sx(sdiv_rem(sx(aw, 32), sx(bw, 32), 32, 0), 32);
                else if (f7 == F7_MULDIV && f3 == 5)
                    val = sx((bw == 0) ? 64'hffff_ffff : 64'(aw / bw), 32);
                else if (f7 == F7_MULDIV && f3 == 6)
                    val = sx(sdiv_rem(sx(aw, 32), sx(bw, 32), 32, 1), 32);
                else if (f7 == F7_MULDIV && f3 == 7)
                    val = sx((bw == 0) ? 64'(aw) : 64'(aw % bw), 32);
                else ill = 1;
            end
            OPC_SYSTEM: begin
                if (ins == INS_EBREAK) r.trap_kind = TRAP_EBREAK;
                else if (ins == INS_ECALL) r.trap_kind = TRAP_ECALL;
                else if (ins == INS_MRET || (f3 != 0 && f3 != 4)) r.trap_kind = TRAP_SYSTEM;
                else ill = 1;
            end
            OPC_MISC_MEM: begin
                if (ins == INS_FENCE_I) r.trap_kind = TRAP_SYSTEM; else ill = 1;
            end
            default: ill = 1;
        endcase
        if (ill) r.trap_kind = TRAP_ILLEGAL;
        if (r.trap_kind != TRAP_NONE) begin
            has_rd = 0;
            r.branch_taken = 0;
            r.next_pc = seq_pc;
            r.mem_kind = MEM_NONE;
            r.mem_address = 0;
            r.mem_size_log2 = 0;
            r.load_signed = 0;
            r.store_data = 0;
        end
        if (!has_rd || r.mem_kind == MEM_LOAD) val = 0;
        r.rd_index = has_rd ? ins[11:7] : 5'd0;
        r.rd_write = has_rd && ins[11:7] != 0;
        r.rd_value = r.rd_write ? val : 64'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && push && !full)
            expected_results.push_back(
                execute_instruction(i_instruction, i_pc, i_rs1_value, i_rs2_value));
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_rd_index !== want.rd_index)
                    report_mismatch("rd_index", o_rd_index, want.rd_index);
                if (o_rd_write !== want.rd_write)
                    report_mismatch("rd_write", o_rd_write, want.rd_write);
                if (o_rd_value !== want.rd_value)
                    report_mismatch("rd_value", o_rd_value, want.rd_value);
                if (o_next_pc !== want.next_pc)
                    report_mismatch("next_pc", o_next_pc, want.next_pc);
                if (o_branch_taken !== want.branch_taken)
                    report_mismatch("branch_taken", o_branch_taken, want.branch_taken);
                if (o_mem_kind !== want.mem_kind)
                    report_mismatch("mem_kind", o_mem_kind, want.mem_kind);
                if (o_mem_address !== want.mem_address)
                    report_mismatch("mem_address", o_mem_address, want.mem_address);
                if (o_mem_size_log2 !== want.mem_size_log2)
                    report_mismatch("mem_size_log2", o_mem_size_log2, want.mem_size_log2);
                if (o_load_signed !== want.load_signed)
                    report_mismatch("load_signed", o_load_signed, want.load_signed);
                if (o_store_data !== want.store_data)
                    report_mismatch("store_data", o_store_data, want.store_data);
                if (o_trap_kind !== want.trap_kind)
                    report_mismatch("trap_kind", o_trap_kind, want.trap_kind);
            end
        end
    end

endmodule

### test/tb_rv64im_instruction_execute.sv
module tb_rv64im_instruction_execute;
    timeunit 1ns;
    timeprecision 1ps;
    import rv64ie_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [31:0] i_instruction = 0;
    logic [63:0] i_pc = 0;
    logic [63:0] i_rs1_value = 0;
    logic [63:0] i_rs2_value = 0;
    logic        empty;
    logic        pop = 0;
    logic [4:0]  o_rd_index;
    logic        o_rd_write;
    logic [63:0] o_rd_value;
    logic [63:0] o_next_pc;
    logic        o_branch_taken;
    logic [1:0]  o_mem_kind;
    logic [63:0] o_mem_address;
    logic [1:0]  o_mem_size_log2;
    logic        o_load_signed;
    logic [63:0] o_store_data;
    logic [2:0]  o_trap_kind;
    int          fail_count;
    int          pending;
    bit          hold_off = 0;

    always #5 i_clk = ~i_clk;

    rv64im_instruction_execute uut (.*);

    rv64ie_checker checker_inst (.*, .o_fail_count(fail_count), .o_pending(pending));

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] operand();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'hffff_ffff_8000_0000;
            4: return 64'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(0, 70));
            default: return rand64();
        endcase
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [6:0] opcodes[13];
        opcodes = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
                    OPC_OPIMM, OPC_OPIMM32, OPC_OP, OPC_OP32, OPC_SYSTEM, OPC_MISC_MEM};
        w = $urandom();
        case ($urandom_range(0, 19))
            0: return w;
            1: return INS_ECALL;
            2: return INS_EBREAK;
            3: return INS_MRET;
            4: return INS_FENCE_I;
            default: begin
                w[6:0] = opcodes[$urandom_range(0, 12)];
                if ($urandom_range(0, 5) != 0) begin
                    case (w[6:0])
                        OPC_OP, OPC_OP32: begin
                            case ($urandom_range(0, 2))
                                0: w[31:25] = F7_BASE;
                                1: w[31:25] = F7_ALT;
                                default: w[31:25] = F7_MULDIV;
                            endcase
                        end
                        OPC_OPIMM: if (w[14:12] inside {3'd1, 3'd5})
                            w[31:26] = $urandom_range(0, 1) ? 6'h10 : 6'h00;
                        OPC_OPIMM32: if (w[14:12] inside {3'd1, 3'd5})
                            w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                        default: ;
                    endcase
                end
                return w;
            end
        endcase
    endfunction

    task automatic send(input logic [31:0] ins, input logic [63:0] pc, input logic [63:0] a,
                        input logic [63:0] b);
        push <= 1;
        i_instruction <= ins;
        i_pc <= pc;
        i_rs1_value <= a;
        i_rs2_value <= b;
        do @(posedge i_clk); while (full);
    endtask

    always @(posedge i_clk) begin
        if (hold_off) pop <= 0;
        else pop <= ($urandom_range(0, 3) != 0) || ($time / 2000) % 3 == 0;
    end

    // long receiver stall while the sender keeps offering
    initial begin
        repeat (600) @(posedge i_clk);
        hold_off <= 1;
        repeat (300) @(posedge i_clk);
        hold_off <= 0;
    end

    initial begin
        logic [31:0] directed[$];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed = '{32'h0000_0013, 32'hfff0_0093, 32'h8000_00b7, 32'hfffff097, 32'h8000_006f,
                     32'h7ff0_80e7, 32'hfe20_8ee3, 32'h0020_c463, 32'h0020_f463,
                     32'hfff0_b083, 32'h0000_4083, 32'hfe20_bfa3, 32'h0220_40b3,
                     32'h0220_50b3, 32'h0220_60bb, 32'h0220_70bb, 32'h0220_10b3,
                     32'h4020_50b3, 32'h43f0_d093, 32'h4010_d09b, 32'h0000_100f,
                     32'h3020_0073, 32'h0010_0073, 32'h0000_0073, 32'h3000_20f3};
        foreach (directed[k])
            send(directed[k], k[0] ? '1 : 64'd0, k[1] ? 64'h8000_0000_0000_0000 : 64'd0,
                 k[2] ? '1 : 64'd0);
        for (int n = 0; n < 1050;) begin
            int burst;
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst; k++, n++)
                send(random_instruction(), operand(), operand(), operand());
            push <= 0;
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
        end
        push <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("PASS rv64im_instruction_execute");
        else $display("FAIL rv64im_instruction_execute");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL rv64im_instruction_execute");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/rv64ie_pkg.sv
design/rv64ie_fifo.sv
design/rv64ie_front.sv
design/rv64ie_back.sv
design/rv64im_instruction_execute.sv
test/rv64ie_checker.sv
test/tb_rv64im_instruction_execute.sv
